[design/jtfu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtfu_pkg
// Shared types, character codes and pattern tables of the text field unescaper.
// ----------------------------------------------------------------------------
package jtfu_pkg;

  localparam int QueueDepthDefault = 4;
  localparam int GrpSlots          = 6;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowG  = 8'h67;
  localparam logic [7:0] ChLowL  = 8'h6c;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowU  = 8'h75;

  typedef enum logic [2:0] {
    MODE_SEARCH = 3'd0,
    MODE_SKIP   = 3'd1,
    MODE_BODY   = 3'd2,
    MODE_ESC    = 3'd3,
    MODE_HEX    = 3'd4,
    MODE_DONE   = 3'd5
  } scan_mode_e;

  // results caused by one input transaction; a verdict is always the final slot
  typedef struct packed {
    logic [GrpSlots-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     verdict;
    logic                     keep;
  } grp_t;

  // key pattern "text": (matched case-insensitively)
  function automatic logic [7:0] key_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = ChQuote;
      3'd1:    r = ChLowT;
      3'd2:    r = 8'h65;
      3'd3:    r = 8'h78;
      3'd4:    r = ChLowT;
      3'd5:    r = ChQuote;
      default: r = 8'h3a;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd1;
      2'd1:    r = 3'd5;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ent_pat(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    if (i == 3'd0) begin
      r = ChAmp;
    end else begin
      case (k)
        2'd1: begin
          case (i)
            3'd1:    r = ChLowA;
            3'd2:    r = 8'h6d;
            3'd3:    r = 8'h70;
            3'd4:    r = 8'h3b;
            default: r = 8'h00;
          endcase
        end
        2'd2, 2'd3: begin
          case (i)
            3'd1:    r = (k == 2'd2) ? ChLowG : ChLowL;
            3'd2:    r = ChLowT;
            3'd3:    r = 8'h3b;
            default: r = 8'h00;
          endcase
        end
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] ent_char(input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd2:    r = 8'h3e;
      2'd3:    r = 8'h3c;
      default: r = ChAmp;
    endcase
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/json_text_field_unescape_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_text_field_unescape_top
// Extracts and unescapes the "text" field of each line of a byte stream.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries raw line bytes, tlast on the final byte of a line.
//   m_axis carries decoded bytes (tuser 0) and, per field, one verdict
//   transaction (tuser 1) whose keep bit says keep or discard the bytes
//   already delivered; tlast marks the last result of one input byte.
//   cfg carries allow_unicode and is always ready.
// path: a group passes the queue entry, then the output register, to m_axis.
// throughput: one input byte per cycle while each byte yields at most one
//   result and the receiver does not stall; a byte yielding k results is
//   walked out by the one-result-per-cycle output stage. The group queue
//   (Depth entries) absorbs short bursts before s_axis_tready drops.
// reset: key search restarts, allow_unicode clears, queue and output empty.
// receiver stall: the output register holds; the queue fills, then
//   s_axis_tready goes low until space frees up.
// ----------------------------------------------------------------------------
module json_text_field_unescape_top import jtfu_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] keep_tweet
  output logic             m_axis_tuser,   // [0] is_verdict
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic       grp_valid, q_not_full, head_valid, pop;
  grp_t       grp, head;
  logic [7:0] out_byte;
  logic       out_keep;

  assign cfg_ready = 1'b1;

  jtfu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eol_i    (s_axis_tlast),
    .cfg_valid_i (cfg_valid),
    .cfg_data_i  (cfg_data),
    .grp_valid_o (grp_valid),
    .grp_ready_i (q_not_full),
    .grp_o       (grp)
  );

  jtfu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (grp_valid),
    .push_grp_i   (grp),
    .not_full_o   (q_not_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  jtfu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .out_verdict_o (m_axis_tuser),
    .out_keep_o    (out_keep),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_keep, out_byte};

endmodule
`default_nettype wire

[design/jtfu_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtfu_front
// Key search and decode state; turns each input byte into a result group.
// ----------------------------------------------------------------------------
module jtfu_front import jtfu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_eol_i,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_data_i,
  output logic            grp_valid_o,
  input  wire logic       grp_ready_i,
  output grp_t            grp_o
);

  scan_mode_e  mode_q, mode_d;
  logic [2:0]  match_q, match_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        hstop_q, hstop_d;
  logic [2:0]  held_q, held_d;
  logic [1:0]  kind_q, kind_d;
  logic        saw_q, saw_d;
  logic        mute_q, mute_d;
  logic        allow_q;
  grp_t        grp;
  logic        accept;

  assign accept      = in_valid_i && grp_ready_i;
  assign in_ready_o  = grp_ready_i;
  assign grp_valid_o = in_valid_i && (grp.cnt != 3'd0);
  assign grp_o       = grp;

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  lc;
    logic [2:0]  p;
    logic [2:0]  n;
    logic [1:0]  k;
    logic [4:0]  hd;
    logic        do_plain;
    logic        do_flush;
    logic        do_cp;
    logic [15:0] cp;

    c        = in_byte_i;
    lc       = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    p        = 3'd0;
    n        = 3'd0;
    k        = kind_q;
    hd       = hex_digit(c);
    do_plain = 1'b0;
    do_flush = 1'b0;
    do_cp    = 1'b0;
    cp       = 16'd0;

    mode_d  = mode_q;
    match_d = match_q;
    hex_d   = hex_q;
    hcnt_d  = hcnt_q;
    hstop_d = hstop_q;
    held_d  = held_q;
    kind_d  = kind_q;
    saw_d   = saw_q;
    mute_d  = mute_q;
    grp     = '0;

    unique case (mode_q)
      MODE_SKIP: mode_d = MODE_BODY;
      MODE_BODY: begin
        if (held_q == 3'd0) begin
          do_plain = 1'b1;
        end else if (kind_q == 2'd0) begin
          if (c == ChLowA || c == ChLowG || c == ChLowL) begin
            kind_d = (c == ChLowA) ? 2'd1 : ((c == ChLowG) ? 2'd2 : 2'd3);
            held_d = 3'd2;
          end else begin
            do_flush = 1'b1;
            do_plain = 1'b1;
          end
        end else if (held_q < ent_len(kind_q) && c == ent_pat(kind_q, held_q)) begin
          held_d = held_q + 3'd1;
          if (held_q + 3'd1 >= ent_len(kind_q)) begin
            if (!mute_d) begin
              grp.bytes[grp.cnt] = ent_char(kind_q);
              grp.cnt = grp.cnt + 3'd1;
            end
            held_d = 3'd0;
            kind_d = 2'd0;
          end
        end else begin
          do_flush = 1'b1;
          do_plain = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_BODY;
        if (c == ChLowU) begin
          mode_d  = MODE_HEX;
          hex_d   = 16'd0;
          hcnt_d  = 2'd0;
          hstop_d = 1'b0;
        end else if (c == ChApos || c == ChQuote || c == ChSlash) begin
          if (!mute_d) begin
            grp.bytes[grp.cnt] = c;
            grp.cnt = grp.cnt + 3'd1;
          end
        end else if (!mute_d) begin
          grp.bytes[grp.cnt] = ChBslash;
          grp.bytes[grp.cnt + 3'd1] = c;
          grp.cnt = grp.cnt + 3'd2;
        end
      end
      MODE_HEX: begin
        if (!hstop_q && hd[4]) begin
          hex_d = {hex_q[11:0], hd[3:0]};
        end else begin
          hstop_d = 1'b1;
        end
        hcnt_d = hcnt_q + 2'd1;
        if (hcnt_q == 2'd3) begin
          do_cp   = 1'b1;
          cp      = hex_d;
          mode_d  = MODE_BODY;
          hcnt_d  = 2'd0;
          hstop_d = 1'b0;
          hex_d   = 16'd0;
        end
      end
      MODE_DONE: ;
      default: begin
        p = (match_q > 3'd6) ? 3'd0 : match_q;
        if (lc == key_char(p)) begin
          if (p == 3'd6) begin
            match_d = 3'd0;
            mode_d  = MODE_SKIP;
            saw_d   = 1'b0;
            mute_d  = 1'b0;
            held_d  = 3'd0;
            kind_d  = 2'd0;
            hex_d   = 16'd0;
            hcnt_d  = 2'd0;
            hstop_d = 1'b0;
          end else begin
            match_d = p + 3'd1;
          end
        end else if (p == 3'd6 && lc == ChLowT) begin
          match_d = 3'd2;
        end else if (c == ChQuote) begin
          match_d = 3'd1;
        end else begin
          match_d = 3'd0;
        end
      end
    endcase

    // broken entity: emit what was held
    if (do_flush) begin
      n = (held_q > ent_len(kind_q)) ? ent_len(kind_q) : held_q;
      for (int i = 0; i < 5; i++) begin
        if (i[2:0] < n && !mute_d) begin
          grp.bytes[grp.cnt] = ent_pat(kind_q, i[2:0]);
          grp.cnt = grp.cnt + 3'd1;
        end
      end
      held_d = 3'd0;
      kind_d = 2'd0;
    end

    if (do_plain) begin
      if (c == ChQuote) begin
        grp.verdict = 1'b1;
        grp.keep = !saw_d || allow_q;
        grp.cnt = grp.cnt + 3'd1;
        mode_d = MODE_DONE;
      end else if (c == ChAmp) begin
        held_d = 3'd1;
        kind_d = 2'd0;
      end else if (c == ChBslash) begin
        mode_d = MODE_ESC;
      end else if (!mute_d) begin
        grp.bytes[grp.cnt] = c;
        grp.cnt = grp.cnt + 3'd1;
      end
    end

    // partial escape sequence closed by the line end
    if (in_eol_i && mode_d == MODE_HEX) begin
      do_cp = 1'b1;
      cp    = hex_d;
    end

    if (do_cp) begin
      if (cp == 16'd0) begin
        mute_d = 1'b1;
      end else if (cp < 16'h0080) begin
        if (!mute_d) begin
          grp.bytes[grp.cnt] = cp[7:0];
          grp.cnt = grp.cnt + 3'd1;
        end
      end else if (cp < 16'h0800) begin
        if (!mute_d) begin
          grp.bytes[grp.cnt] = {3'b110, cp[10:6]};
          grp.bytes[grp.cnt + 3'd1] = {2'b10, cp[5:0]};
          grp.cnt = grp.cnt + 3'd2;
        end
        saw_d = 1'b1;
      end else begin
        if (!mute_d) begin
          grp.bytes[grp.cnt] = {4'b1110, cp[15:12]};
          grp.bytes[grp.cnt + 3'd1] = {2'b10, cp[11:6]};
          grp.bytes[grp.cnt + 3'd2] = {2'b10, cp[5:0]};
          grp.cnt = grp.cnt + 3'd3;
        end
        saw_d = 1'b1;
      end
    end

    if (in_eol_i) begin
      k = kind_d;
      if (mode_d == MODE_BODY && held_d != 3'd0) begin
        n = (held_d > ent_len(k)) ? ent_len(k) : held_d;
        for (int i = 0; i < 5; i++) begin
          if (i[2:0] < n && !mute_d) begin
            grp.bytes[grp.cnt] = ent_pat(k, i[2:0]);
            grp.cnt = grp.cnt + 3'd1;
          end
        end
      end
      if (mode_d == MODE_ESC && !mute_d) begin
        grp.bytes[grp.cnt] = ChBslash;
        grp.cnt = grp.cnt + 3'd1;
      end
      if (mode_d == MODE_BODY || mode_d == MODE_ESC || mode_d == MODE_HEX ||
          mode_d == MODE_SKIP) begin
        grp.verdict = 1'b1;
        grp.keep = !saw_d || allow_q;
        grp.cnt = grp.cnt + 3'd1;
      end
      mode_d  = MODE_SEARCH;
      match_d = 3'd0;
      held_d  = 3'd0;
      kind_d  = 2'd0;
      hex_d   = 16'd0;
      hcnt_d  = 2'd0;
      hstop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SEARCH;
      match_q <= 3'd0;
      hex_q   <= 16'd0;
      hcnt_q  <= 2'd0;
      hstop_q <= 1'b0;
      held_q  <= 3'd0;
      kind_q  <= 2'd0;
      saw_q   <= 1'b0;
      mute_q  <= 1'b0;
      allow_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        allow_q <= cfg_data_i;
      end
      if (accept) begin
        mode_q  <= mode_d;
        match_q <= match_d;
        hex_q   <= hex_d;
        hcnt_q  <= hcnt_d;
        hstop_q <= hstop_d;
        held_q  <= held_d;
        kind_q  <= kind_d;
        saw_q   <= saw_d;
        mute_q  <= mute_d;
      end
    end
  end

endmodule
`default_nettype wire

[design/jtfu_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtfu_queue
// Small queue of result groups between the decoder and the output serializer.
// ----------------------------------------------------------------------------
module jtfu_queue import jtfu_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  grp_t      push_grp_i,
  output logic      not_full_o,
  output logic      head_valid_o,
  output grp_t      head_o,
  input  wire logic pop_i
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  grp_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign not_full_o   = (count_q != CW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && not_full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[design/jtfu_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtfu_back
// Walks the head group one result per cycle, while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module jtfu_back import jtfu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  grp_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_verdict_o,
  output logic             out_keep_o,
  output logic             out_last_o
);

  logic [2:0] pos_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       verdict_q, keep_q, last_q;
  logic       load, is_last, is_v;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = (pos_q == head_i.cnt - 3'd1);
  assign is_v    = head_i.verdict && is_last;
  assign pop_o   = load && is_last;

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign out_verdict_o = verdict_q;
  assign out_keep_o    = keep_q;
  assign out_last_o    = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= is_v ? 8'h00 : head_i.bytes[pos_q];
      verdict_q <= is_v;
      keep_q    <= is_v && head_i.keep;
      last_q    <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= is_last ? 3'd0 : pos_q + 3'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[design/jtfu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtfu_checker
// Port-level checks on the result stream of the text field unescaper.
// ----------------------------------------------------------------------------
module jtfu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // stalled transaction stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("m_axis payload changed under stall");

  // a verdict always closes the results of its input byte
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("verdict not marked last");

  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("verdict carries a byte");

  a_keep_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[8])
    else $error("keep flag set on a data byte");

endmodule

bind json_text_field_unescape_top jtfu_checker u_checker (.*);
`default_nettype wire
